// File: hw/rtl/csa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants for the calendar snapshot block
// Item formats for both channels, the packed snapshot date and the
// month-length table.
// ----------------------------------------------------------------------------
package csa_pkg;

   localparam logic FUNC_STORE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam int unsigned SECS_PER_MIN    = 60;
   localparam int unsigned MINS_PER_HOUR   = 60;
   localparam int unsigned HOURS_PER_DAY   = 24;
   localparam int unsigned DAYS_PER_WEEK   = 7;
   localparam int unsigned MONTHS_PER_YEAR = 12;
   localparam int unsigned MAX_ELAPSED     = 60;
   localparam int unsigned YEAR_BASE       = 1900;
   localparam int unsigned MONTH_FEB       = 1;

   localparam logic [4:0] MONTH_DAYS [0:11] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic        func;
      logic        slot;
      logic [47:0] now_seconds;
      logic [47:0] snap_seconds;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [2:0]  weekday;
      logic [4:0]  day_of_month;
      logic [3:0]  month;
      logic [17:0] year;
      logic        dst;
   } req_type;

   typedef struct packed {
      logic [5:0]  res_second;
      logic [5:0]  res_minute;
      logic [4:0]  res_hour;
      logic [2:0]  res_weekday;
      logic [4:0]  res_day;
      logic [3:0]  res_month;
      logic [17:0] res_year;
      logic        res_dst;
   } rsp_type;

   typedef struct packed {
      logic [17:0] year;
      logic        dst;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [2:0]  weekday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } date_type;

   // Length of a month; codes past December count 31 days.
   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      if (month >= 4'(MONTHS_PER_YEAR)) begin
         days = 5'd31;
      end else if (month == 4'(MONTH_FEB) && leap) begin
         days = 5'd29;
      end else begin
         days = MONTH_DAYS[month];
      end
      return days;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/csa_leap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csa_leap: Gregorian leap-year test
// Tests year+1900 for leap; divisibility by 25 through one multiply by a
// scaled reciprocal, divisibility by 4 and 16 from the low bits.
// ----------------------------------------------------------------------------
module csa_leap
   import csa_pkg::*;
(
   input  wire logic [17:0] year,
   output logic             leap
);

   localparam int unsigned FRAC_W = 26;
   localparam int unsigned RECIP  = ((2 ** FRAC_W) + 24) / 25;
   localparam int unsigned RECIP_W = $clog2(RECIP + 1);

   logic [18:0]                 full_year;
   logic [19+RECIP_W-1:0]       prod;
   logic                        div25;

   always_comb begin
      full_year = {1'b0, year} + 19'(YEAR_BASE);
      prod      = (19+RECIP_W)'(full_year) * (19+RECIP_W)'(RECIP);
      // a multiple of 25 leaves a fraction below the reciprocal
      div25     = prod[FRAC_W-1:0] < FRAC_W'(RECIP);
      leap      = (full_year[1:0] == 2'd0) && (!div25 || (full_year[3:0] == 4'd0));
   end

endmodule
`default_nettype wire

// File: hw/rtl/csa_advance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csa_advance: advance a snapshot date by the elapsed seconds
// Clamps now minus snapshot time to 0..60, so at most one carry runs from
// seconds up through the year.
// ----------------------------------------------------------------------------
module csa_advance
   import csa_pkg::*;
(
   input  wire logic [47:0] now_seconds,
   input  wire logic [47:0] snap_seconds,
   input  wire date_type    date,
   input  wire logic        leap,
   output rsp_type          result
);

   logic [48:0] diff;
   logic [5:0]  elapsed;
   logic [6:0]  sec_sum;
   logic [6:0]  min_inc;
   logic [5:0]  hour_inc;
   logic [3:0]  wd_inc;
   logic [5:0]  day_inc;
   logic [4:0]  mon_inc;
   logic        c_min;
   logic        c_hour;
   logic        c_day;
   logic        c_month;
   logic        c_year;

   always_comb begin
      diff = {1'b0, now_seconds} - {1'b0, snap_seconds};
      if (diff[48] || diff[47:0] == 48'd0) begin
         elapsed = 6'd0;
      end else if (diff[47:0] > 48'(MAX_ELAPSED)) begin
         elapsed = 6'(MAX_ELAPSED);
      end else begin
         elapsed = diff[5:0];
      end

      result         = '0;
      result.res_dst = date.dst;

      // seconds: an out-of-range second carries on the first tick
      sec_sum = {1'b0, date.second} + {1'b0, elapsed};
      c_min   = 1'b0;
      if (elapsed == 6'd0) begin
         result.res_second = date.second;
      end else if (date.second >= 6'(SECS_PER_MIN)) begin
         result.res_second = elapsed - 6'd1;
         c_min             = 1'b1;
      end else if (sec_sum >= 7'(SECS_PER_MIN)) begin
         result.res_second = 6'(sec_sum - 7'(SECS_PER_MIN));
         c_min             = 1'b1;
      end else begin
         result.res_second = sec_sum[5:0];
      end

      min_inc           = {1'b0, date.minute} + 7'd1;
      c_hour            = c_min && (min_inc >= 7'(MINS_PER_HOUR));
      result.res_minute = !c_min ? date.minute : (c_hour ? 6'd0 : min_inc[5:0]);

      hour_inc        = {1'b0, date.hour} + 6'd1;
      c_day           = c_hour && (hour_inc >= 6'(HOURS_PER_DAY));
      result.res_hour = !c_hour ? date.hour : (c_day ? 5'd0 : hour_inc[4:0]);

      wd_inc = {1'b0, date.weekday} + 4'd1;
      if (!c_day) begin
         result.res_weekday = date.weekday;
      end else if (wd_inc >= 4'(DAYS_PER_WEEK)) begin
         result.res_weekday = 3'd0;
      end else begin
         result.res_weekday = wd_inc[2:0];
      end

      day_inc        = {1'b0, date.day} + 6'd1;
      c_month        = c_day && (day_inc > {1'b0, days_in(date.month, leap)});
      result.res_day = !c_day ? date.day : (c_month ? 5'd1 : day_inc[4:0]);

      mon_inc          = {1'b0, date.month} + 5'd1;
      c_year           = c_month && (mon_inc >= 5'(MONTHS_PER_YEAR));
      result.res_month = !c_month ? date.month : (c_year ? 4'd0 : mon_inc[3:0]);

      result.res_year = c_year ? date.year + 18'd1 : date.year;
   end

endmodule
`default_nettype wire

// File: hw/rtl/calendar_snapshot_advance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_snapshot_advance: calendar snapshot store and advance
// Keeps per-slot snapshots of epoch seconds and broken-down date; a query
// returns the snapshot date moved forward by the clamped elapsed time.
// ----------------------------------------------------------------------------
//   channel  direction  ports                            item
//   req      in         req_valid req_stall req_data     store or query
//   rsp      out        rsp_valid rsp_stall rsp_data     advanced date (query only)
//
// One item per cycle while the result is not stalled: an item is accepted into the
// input register, then a query loads the result register, which drives rsp_valid.
// A store writes its slot and the leap flag of its year as it leaves the
// input register, and gives no result. Reset clears all slots to zero.
// A stalled result holds a waiting query in the input register; stores pass.
// ----------------------------------------------------------------------------
module calendar_snapshot_advance
   import csa_pkg::*;
#(
   parameter int NUM_SLOTS = 2
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   req_type            in_ff;
   logic               in_valid_ff;
   logic               in_valid_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [47:0]        secs_ff [NUM_SLOTS];
   date_type           date_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] leap_ff;

   logic               req_take;
   logic               rsp_take;
   logic               in_move;
   logic               is_query;
   logic [IDX_W-1:0]   idx;
   logic               store_leap;
   date_type           store_date;
   rsp_type            adv_result;

   always_comb begin
      is_query  = (in_ff.func == FUNC_QUERY);
      idx       = (NUM_SLOTS > 1) ? IDX_W'(in_ff.slot) : '0;
      rsp_take  = rsp_valid_ff && !rsp_stall;
      in_move   = in_valid_ff && (!is_query || !rsp_valid_ff || !rsp_stall);
      req_stall = in_valid_ff && !in_move;
      req_take  = req_valid && !req_stall;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (in_move && is_query) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      store_date.second  = in_ff.second;
      store_date.minute  = in_ff.minute;
      store_date.hour    = in_ff.hour;
      store_date.weekday = in_ff.weekday;
      store_date.day     = in_ff.day_of_month;
      store_date.month   = in_ff.month;
      store_date.dst     = in_ff.dst;
      store_date.year    = in_ff.year;
   end

   csa_leap u_leap (
      .year (in_ff.year),
      .leap (store_leap)
   );

   csa_advance u_advance (
      .now_seconds  (in_ff.now_seconds),
      .snap_seconds (secs_ff[idx]),
      .date         (date_ff[idx]),
      .leap         (leap_ff[idx]),
      .result       (adv_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
      if (in_move && is_query) begin
         rsp_ff <= adv_result;
      end
   end

   // snapshot store: written by store items as they leave the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            secs_ff[i] <= '0;
            date_ff[i] <= '0;
         end
         leap_ff <= '0;
      end else if (in_move && !is_query) begin
         secs_ff[idx] <= in_ff.snap_seconds;
         date_ff[idx] <= store_date;
         leap_ff[idx] <= store_leap;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
